[hdl/ebtu_pkg.sv]
// Package for the error-bounded timestamp unit: item structs, register
// indexes and field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ebtu_pkg;

  localparam int unsigned TimeW  = 64;
  localparam int unsigned ErrW   = 32;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DRIFT_RATE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DRIFT_PERIOD = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BASE_ERROR   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ERROR    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LIVE_LIMIT   = 3'd4;

  // Operation codes
  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [TimeW-1:0] steady_now;
    logic [TimeW-1:0] steady_low;
    logic [TimeW-1:0] real_now;
  } req_t;

  typedef struct packed {
    logic [TimeW-1:0] real_time;
    logic [ErrW-1:0]  error_bound;
    logic             replaced;
    logic             stale_warning;
  } rsp_t;

endpackage

`default_nettype wire

[hdl/error_bounded_timestamp_unit_top.sv]
// Error-bounded timestamp unit: reference keeping, drift extrapolation and
// update selection around one shared multiply/divide unit. Uses ebtu_pkg.
`timescale 1ns / 1ps
`default_nettype none

// How to use:
//   req channel (req_valid / req_stall / req): one item per operation. A query
//   returns the kept reference extrapolated to steady_now with its drift-grown
//   error. An update offers a new reference seen inside [steady_low, steady_now]
//   and is kept when its error is not larger than the kept one's.
//   rsp channel (rsp_valid / rsp_stall / rsp): exactly one item per request.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register writes,
//   ready outside reset; write only while the unit is idle. Unknown indexes drop.
// Timing: one 32x32 multiplier and a radix-2 restoring divider (one quotient bit
//   per cycle) compute drift = rate * d / period. A query or first update runs
//   the drift pass once; a later update runs it twice (reference age, then poll
//   window). A saturated drift (d >= max_error or rate >= period) skips the
//   divider for that pass. req_stall is high from accept until the result is
//   loaded into the output register, so one item is in flight.
// Reset (rst, synchronous): registers return to their defaults, the reference
//   is cleared to zero and marked absent, and any pending result is dropped.
// Receiver stall: the result holds in the output register; a finished item
//   waits in its final step until the output register is free.
module error_bounded_timestamp_unit_top
  import ebtu_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // request channel
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire req_t               req,
  // response channel
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output rsp_t                    rsp,
  // configuration write channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [TimeW-1:0]   cfg_data
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIFF = 3'd1;  // age and window differences
  localparam logic [2:0] S_MUL  = 3'd2;  // saturation check and rate * d
  localparam logic [2:0] S_DIV  = 3'd3;  // one quotient bit per cycle
  localparam logic [2:0] S_OLD  = 3'd4;  // error and time of kept reference
  localparam logic [2:0] S_SUM1 = 3'd5;  // source error + window
  localparam logic [2:0] S_SUM2 = 3'd6;  // + drift, cap: candidate error
  localparam logic [2:0] S_RES  = 3'd7;  // choose, update reference, emit

  // Configuration registers
  logic [ErrW-1:0]  drift_rate;
  logic [ErrW-1:0]  drift_den;
  logic [ErrW-1:0]  src_err;
  logic [ErrW-1:0]  max_error;
  logic [TimeW-1:0] liveliness_limit;

  // Reference
  logic [TimeW-1:0] ref_steady;
  logic [TimeW-1:0] ref_real;
  logic [ErrW-1:0]  ref_error;
  logic             ref_valid;

  // Item working registers
  logic [2:0]       state;
  logic             pass;      // 0: drift of age, 1: drift of window
  logic [4:0]       count;
  logic             op;
  logic [TimeW-1:0] now;
  logic [TimeW-1:0] low;
  logic [TimeW-1:0] real_in;
  logic [TimeW-1:0] age;
  logic [TimeW-1:0] win;
  logic [ErrW-1:0]  rem;
  logic [ErrW-1:0]  dq;        // dividend low half, then quotient (drift)
  logic [ErrW-1:0]  old_err;
  logic [TimeW-1:0] extrap;
  logic [TimeW-1:0] sum1;
  logic [ErrW-1:0]  new_err;

  // Shared drift unit datapath
  logic [TimeW-1:0] mul_d;
  logic             drift_sat;
  logic [TimeW-1:0] prod;
  logic [ErrW:0]    div_shift;
  logic [ErrW:0]    div_diff;
  logic             div_ge;
  logic [2:0]       drift_done_state;

  // Result arithmetic
  logic [ErrW:0]    old_sum;
  logic [ErrW-1:0]  old_err_calc;
  logic [TimeW:0]   sum1_wide;
  logic [TimeW:0]   sum2_wide;
  logic [TimeW-1:0] sum2_sat;
  logic [ErrW-1:0]  new_err_calc;
  logic             slot_free;
  logic             take_new;

  // Hold off both channels while in reset
  assign req_stall = rst || (state != S_IDLE);
  assign cfg_ready = !rst;
  assign slot_free = !rsp_valid || !rsp_stall;

  assign mul_d     = pass ? win : age;
  assign drift_sat = (mul_d >= {{(TimeW-ErrW){1'b0}}, max_error}) ||
                     (drift_rate >= drift_den);
  // 32x32 product; the high half stays below the period when not saturated
  assign prod      = {{(TimeW-ErrW){1'b0}}, drift_rate} *
                     {{(TimeW-ErrW){1'b0}}, mul_d[ErrW-1:0]};

  assign div_shift = {rem, dq[ErrW-1]};
  assign div_diff  = div_shift - {1'b0, drift_den};
  assign div_ge    = (div_shift >= {1'b0, drift_den});
  assign drift_done_state = pass ? S_SUM1 : S_OLD;

  assign old_sum      = {1'b0, ref_error} + {1'b0, dq};
  assign old_err_calc = (old_sum < {1'b0, max_error}) ? old_sum[ErrW-1:0] : max_error;

  assign sum1_wide    = {1'b0, win} + {{(TimeW-ErrW+1){1'b0}}, src_err};
  assign sum2_wide    = {1'b0, sum1} + {{(TimeW-ErrW+1){1'b0}}, dq};
  assign sum2_sat     = sum2_wide[TimeW] ? {TimeW{1'b1}} : sum2_wide[TimeW-1:0];
  assign new_err_calc = (sum2_sat < {{(TimeW-ErrW){1'b0}}, max_error}) ?
                        sum2_sat[ErrW-1:0] : max_error;

  // Keep the candidate when its error is not larger than the kept one's
  assign take_new = !(new_err > old_err);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      drift_rate       <= 32'd100;
      drift_den        <= 32'd1000000;
      src_err          <= 32'd1000;
      max_error        <= 32'hFFFF_FFFF;
      liveliness_limit <= 64'd50000000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DRIFT_RATE:   drift_rate       <= cfg_data[ErrW-1:0];
        CFG_DRIFT_PERIOD: drift_den        <= cfg_data[ErrW-1:0];
        CFG_BASE_ERROR:   src_err          <= cfg_data[ErrW-1:0];
        CFG_MAX_ERROR:    max_error        <= cfg_data[ErrW-1:0];
        CFG_LIVE_LIMIT:   liveliness_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output valid: raise on a finished item, drop once the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_RES && slot_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pass       <= 1'b0;
      count      <= '0;
      ref_valid  <= 1'b0;
      ref_steady <= '0;
      ref_real   <= '0;
      ref_error  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            pass  <= 1'b0;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          state <= S_MUL;
        end
        S_MUL: begin
          count <= '0;
          state <= drift_sat ? drift_done_state : S_DIV;
        end
        S_DIV: begin
          count <= count + 5'd1;
          if (count == 5'd31) begin
            state <= drift_done_state;
          end
        end
        S_OLD: begin
          if (op == OP_UPDATE && ref_valid) begin
            pass  <= 1'b1;
            state <= S_MUL;
          end else begin
            state <= S_RES;
          end
        end
        S_SUM1: begin
          state <= S_SUM2;
        end
        S_SUM2: begin
          state <= S_RES;
        end
        S_RES: begin
          if (slot_free) begin
            state <= S_IDLE;
            if (op == OP_UPDATE && (!ref_valid || take_new)) begin
              ref_valid  <= 1'b1;
              ref_steady <= now;
              ref_real   <= real_in;
              ref_error  <= ref_valid ? new_err : max_error;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          op      <= req.operation;
          now     <= req.steady_now;
          low     <= req.steady_low;
          real_in <= req.real_now;
        end
      end
      S_DIFF: begin
        age <= now - ref_steady;
        win <= now - low;
      end
      S_MUL: begin
        if (drift_sat) begin
          dq <= max_error;
        end else begin
          rem <= prod[TimeW-1:ErrW];
          dq  <= prod[ErrW-1:0];
        end
      end
      S_DIV: begin
        rem <= div_ge ? div_diff[ErrW-1:0] : div_shift[ErrW-1:0];
        dq  <= {dq[ErrW-2:0], div_ge};
      end
      S_OLD: begin
        old_err <= old_err_calc;
        extrap  <= ref_real + age;
      end
      S_SUM1: begin
        sum1 <= sum1_wide[TimeW] ? {TimeW{1'b1}} : sum1_wide[TimeW-1:0];
      end
      S_SUM2: begin
        new_err <= new_err_calc;
      end
      S_RES: begin
        if (slot_free) begin
          if (op == OP_UPDATE && (!ref_valid || take_new)) begin
            rsp.real_time     <= real_in;
            rsp.error_bound   <= ref_valid ? new_err : max_error;
            rsp.replaced      <= 1'b1;
            rsp.stale_warning <= 1'b0;
          end else begin
            rsp.real_time     <= extrap;
            rsp.error_bound   <= old_err;
            rsp.replaced      <= 1'b0;
            rsp.stale_warning <= (op == OP_UPDATE) && (age > liveliness_limit);
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // The divider remainder stays below the period while dividing
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < drift_den))
    else $error("divider remainder not below period");

  // Once a reference exists it is never dropped
  a_ref_keep: assert property (@(posedge clk) disable iff (rst)
    ref_valid |=> ref_valid)
    else $error("reference valid bit fell");

  // A new result only comes out of the final step
  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_RES))
    else $error("response raised outside final step");

  // A replacing result leaves a reference behind, and never warns
  a_rep_ref: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.replaced) |-> (ref_valid && !rsp.stale_warning))
    else $error("replaced result without reference or with warning");
`endif

endmodule

`default_nettype wire
